### rtl/previous_in_range_query_macros.svh
// assertion macros for the previous_in_range_query checker
// expects clk and arst_n in the scope where a macro is used
`ifndef PREVIOUS_IN_RANGE_QUERY_MACROS_SVH
`define PREVIOUS_IN_RANGE_QUERY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PIRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PIRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pirq_pkg.sv
// shared types and codes for the previous-in-range query block
// no dependencies
package pirq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_QUERY,
		OP_CLEAR
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_RANGE
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	localparam logic signed [10:0] NONE_POS = -11'sd1;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] value;
		logic [9:0]         position;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
	} req_t;

	typedef struct packed {
		logic signed [10:0] found_position;
		status_t            status;
	} rsp_t;

endpackage

### rtl/previous_in_range_query.sv
// previous_in_range_query: append-only value store with a backward range search
// depends on pirq_pkg
//
// usage:
//   a request is taken on a rising edge with start high and busy low. exactly
//   one result follows: done strobes for one cycle with result valid, and the
//   receiver must take it then, it cannot hold results off.
//   push appends request.value and answers with its position (status full and
//   -1 when the store holds MAX_ENTRIES values). clear empties the store.
//   query answers the greatest position j <= request.position whose value lies
//   in range_low..range_high, or -1; a position at or past the count gives -1
//   with status range.
// timing:
//   push, clear, unused opcodes and out-of-range queries strobe done in the cycle
//   after the request; busy stays low so a request may be taken every cycle.
//   a valid query scans the value store backward, one entry per cycle through
//   the single read port and one signed range compare; each entry is read into
//   the registered read data, compared, and a hit or a miss at entry 0 ends the
//   scan and registers done; busy holds off new requests during the scan.
// reset: the entry count and the control state clear at once; the store is
//   not cleared, as only entries below the count are ever read.
module previous_in_range_query #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pirq_pkg::req_t request,
	output logic          done,
	output pirq_pkg::rsp_t result
);
	import pirq_pkg::*;

	localparam int AW     = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int WIDE_W = (CNT_W > 11) ? CNT_W : 11;

	logic signed [31:0] mem [MAX_ENTRIES];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [AW-1:0]      scan_addr_q;
	logic               more_q;
	logic [AW-1:0]      rd_addr_q;
	logic               rd_vld_q;
	logic signed [31:0] rdata_q;
	logic signed [31:0] lo_q, hi_q;
	logic               done_q;
	rsp_t               result_q;

	logic             accept;
	logic [WIDE_W-1:0] pos_w, cnt_w, hit_w;
	logic             full, pos_err;
	logic             wr_en, rd_en, hit, miss_end, scan_start;
	logic             done_d;
	rsp_t             rsp_d;

	assign accept  = start && !busy;
	assign pos_w   = WIDE_W'(request.position);
	assign cnt_w   = WIDE_W'(count_q);
	assign full    = (count_q == CNT_W'(MAX_ENTRIES));
	assign pos_err = (pos_w >= cnt_w);
	assign hit_w   = WIDE_W'(rd_addr_q);

	// shared compare unit on the registered read data
	assign hit      = rd_vld_q && (rdata_q >= lo_q) && (rdata_q <= hi_q);
	assign miss_end = rd_vld_q && !hit && (rd_addr_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && request.opcode == OP_QUERY && !pos_err) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || miss_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != S_IDLE);
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		scan_start = 1'b0;
		done_d     = 1'b0;
		rsp_d      = '{found_position: NONE_POS, status: ST_OK};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (request.opcode)
						OP_PUSH: begin
							done_d = 1'b1;
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								wr_en = 1'b1;
								rsp_d.found_position = $signed(cnt_w[10:0]);
							end
						end
						OP_QUERY: begin
							if (pos_err) begin
								done_d       = 1'b1;
								rsp_d.status = ST_RANGE;
							end else begin
								scan_start = 1'b1;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				rd_en = more_q;
				if (hit) begin
					done_d               = 1'b1;
					rsp_d.found_position = $signed(hit_w[10:0]);
				end else if (miss_end) begin
					done_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			more_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && request.opcode == OP_CLEAR) begin
				count_q <= '0;
			end
			if (scan_start) begin
				more_q <= 1'b1;
			end else if (rd_en && scan_addr_q == '0) begin
				more_q <= 1'b0;
			end else if (state_d == S_IDLE) begin
				more_q <= 1'b0;
			end
			rd_vld_q <= rd_en && (state_d == S_SCAN);
		end
	end

	// payload registers and the value store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= request.value;
		end
		if (rd_en) begin
			rdata_q   <= mem[scan_addr_q];
			rd_addr_q <= scan_addr_q;
		end
		if (scan_start) begin
			scan_addr_q <= pos_w[AW-1:0];
			lo_q        <= request.range_low;
			hi_q        <= request.range_high;
		end else if (rd_en) begin
			scan_addr_q <= scan_addr_q - AW'(1);
		end
		if (done_d) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/pirq_checker.sv
// port-level checks for previous_in_range_query, bound to the top level
// depends on pirq_pkg and previous_in_range_query_macros.svh
`include "previous_in_range_query_macros.svh"

module pirq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input pirq_pkg::req_t request,
	input logic           done,
	input pirq_pkg::rsp_t result
);
	import pirq_pkg::*;

	`PIRQ_ASSERT_NOW(a_done_not_busy, done, !busy, "result strobed while still busy")
	`PIRQ_ASSERT_NOW(a_fall_gives_done, $fell(busy), done, "query ended without a result")
	`PIRQ_ASSERT_NEXT(a_quick_ops, start && !busy && request.opcode != OP_QUERY, done && !busy, "push or clear request did not answer in one cycle")
	`PIRQ_ASSERT_NOW(a_error_none, done && result.status != ST_OK, result.found_position == NONE_POS, "error result carries a position")
	`PIRQ_ASSERT_NEXT(a_push_ok_pos, start && !busy && request.opcode == OP_PUSH, result.status == ST_FULL || result.found_position != NONE_POS, "accepted push reported no position")

endmodule

bind previous_in_range_query pirq_checker u_pirq_checker (.*);
